### rtl/pic_pkg.sv
// Package with shared types and constants for the platform interrupt controller.
package pic_pkg;

    // Request type codes.
    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_LEVEL  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_type_t;

    // Register window offsets.
    localparam logic [21:0] OFS_PRIORITY  = 22'h000000;
    localparam logic [21:0] OFS_PENDING   = 22'h001000;
    localparam logic [21:0] OFS_ENABLE    = 22'h002000;
    localparam logic [21:0] OFS_THRESHOLD = 22'h200000;
    localparam logic [21:0] OFS_CLAIM     = 22'h200004;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVAL,
        ST_OUT
    } pic_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic evaluate;
    } pic_cmd_t;

endpackage

### rtl/platform_interrupt_controller_core.sv
// The controller sequences capture, execute and claim evaluation one item at a
// time: a transfer is captured, executed and evaluated in order, then the result
// is offered until taken; no new transfer is accepted before that, so an output
// stall holds the input.
// Reset: asynchronous active-low rst_n clears priorities, enables, pending,
// in-service, levels and threshold.
module platform_interrupt_controller_core #(
    parameter int NUM_LINES     = 32,
    parameter int PRIORITY_BITS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [21:0] reg_offset,
    input  logic [31:0] write_data,
    input  logic [4:0]  source_line,
    input  logic        source_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        irq_to_hart
);
    import pic_pkg::*;

    pic_cmd_t cmd;

    // Sequencer.
    pic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Register file and claim logic.
    pic_dp #(
        .NUM_LINES     (NUM_LINES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_type),
        .reg_offset   (reg_offset),
        .write_data   (write_data),
        .source_line  (source_line),
        .source_level (source_level),
        .read_data    (read_data),
        .irq_to_hart  (irq_to_hart)
    );
endmodule

### rtl/pic_ctrl.sv
// Controller state machine that sequences one transfer through the datapath.
module pic_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pic_pkg::pic_cmd_t cmd
);
    import pic_pkg::*;

    pic_state_t state_reg;
    pic_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_EVAL;
            ST_EVAL: state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        ready        = (state_reg == ST_IDLE);
        out_valid    = (state_reg == ST_OUT);
        cmd.capture  = (state_reg == ST_IDLE) && valid;
        cmd.execute  = (state_reg == ST_EXEC);
        cmd.evaluate = (state_reg == ST_EVAL);
    end

    // Output valid is only raised after evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.evaluate))
        else $error("result shown without evaluation");
    // A capture leads to execution next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("capture not followed by execute");
    // Never accept while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ready && out_valid))
        else $error("ready during output");
endmodule

### rtl/pic_dp.sv
// Datapath holding the controller state, register decode and claim selection.
module pic_dp #(
    parameter int NUM_LINES     = 32,
    parameter int PRIORITY_BITS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pic_pkg::pic_cmd_t cmd,
    input  logic [1:0]        req_type,
    input  logic [21:0]       reg_offset,
    input  logic [31:0]       write_data,
    input  logic [4:0]        source_line,
    input  logic              source_level,
    output logic [31:0]       read_data,
    output logic              irq_to_hart
);
    import pic_pkg::*;

    localparam int WORDS = (NUM_LINES + 31) / 32;
    localparam int NW    = WORDS * 32;
    localparam int LB    = $clog2(NW);
    localparam int WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TN    = 2 ** LB;

    // Captured request.
    logic [1:0]  type_reg;
    logic [21:0] ofs_reg;
    logic [31:0] data_reg;
    logic [4:0]  line_reg;
    logic        level_reg;

    // Controller state.
    logic [PRIORITY_BITS-1:0] prio_reg [NUM_LINES];
    logic [NW-1:0]            en_reg;
    logic [NW-1:0]            pend_reg;
    logic [NW-1:0]            isv_reg;
    logic [NW-1:0]            lvl_reg;
    logic [PRIORITY_BITS-1:0] thr_reg;
    logic [LB-1:0]            best_reg;
    logic [31:0]              rd_reg;
    logic                     irq_reg;

    // Claim selection: a binary compare tree over the lines. Leaves sit at
    // TN + line; each node keeps its left child unless the right child is
    // strictly higher, so ties go to the lowest line.
    logic [LB-1:0]            best;
    logic                     node_v [1:2*TN-1];
    logic [PRIORITY_BITS-1:0] node_p [1:2*TN-1];
    logic [LB-1:0]            node_n [1:2*TN-1];
    always_comb
    begin
        for (int i = 0; i < TN; i++)
        begin
            node_n[TN+i] = LB'(i);
            if (i >= 1 && i < NUM_LINES)
            begin
                node_v[TN+i] = pend_reg[i] && en_reg[i] && (prio_reg[i] > thr_reg);
                node_p[TN+i] = prio_reg[i];
            end
            else
            begin
                node_v[TN+i] = 1'b0;
                node_p[TN+i] = '0;
            end
        end
        for (int k = TN - 1; k >= 1; k--)
        begin
            if (node_v[2*k+1] && (!node_v[2*k] || node_p[2*k+1] > node_p[2*k]))
            begin
                node_v[k] = node_v[2*k+1];
                node_p[k] = node_p[2*k+1];
                node_n[k] = node_n[2*k+1];
            end
            else
            begin
                node_v[k] = node_v[2*k];
                node_p[k] = node_p[2*k];
                node_n[k] = node_n[2*k];
            end
        end
        best = node_v[1] ? node_n[1] : '0;
    end

    // Decode of the captured offset.
    logic          aligned;
    logic          hit_prio, hit_pend, hit_en, hit_thr, hit_claim;
    logic [19:0]   idx;
    logic [WB-1:0] widx;
    logic [19:0]   pidx, eidx;
    always_comb
    begin
        aligned   = (ofs_reg[1:0] == 2'b00);
        idx       = ofs_reg[21:2];
        pidx      = idx - OFS_PENDING[21:2];
        eidx      = idx - OFS_ENABLE[21:2];
        hit_prio  = aligned && ({10'd0, ofs_reg} < 32'(4 * NUM_LINES));
        hit_pend  = aligned && ofs_reg >= OFS_PENDING
                    && {10'd0, ofs_reg} < 32'(OFS_PENDING) + 32'(4 * WORDS);
        hit_en    = aligned && ofs_reg >= OFS_ENABLE
                    && {10'd0, ofs_reg} < 32'(OFS_ENABLE) + 32'(4 * WORDS);
        hit_thr   = aligned && ofs_reg == OFS_THRESHOLD;
        hit_claim = aligned && ofs_reg == OFS_CLAIM;
        widx      = hit_pend ? WB'(pidx) : WB'(eidx);
    end

    logic [NW-1:0] valid_mask;
    always_comb
    begin
        valid_mask = '0;
        for (int n = 1; n < NUM_LINES; n++)
            valid_mask[n] = 1'b1;
    end

    logic        cl_ok;
    logic [LB-1:0] cl_line;
    assign cl_line = LB'(data_reg);
    assign cl_ok   = data_reg != 0 && data_reg < 32'(NUM_LINES)
                     && isv_reg[cl_line] && en_reg[cl_line];

    logic [LB-1:0] sl;
    assign sl = LB'(line_reg);

    // Capture stage.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg  <= req_type;
            ofs_reg   <= reg_offset;
            data_reg  <= write_data;
            line_reg  <= source_line;
            level_reg <= source_level;
        end
    end

    // Execute and evaluate stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_LINES; n++)
                prio_reg[n] <= '0;
            en_reg   <= '0;
            pend_reg <= '0;
            isv_reg  <= '0;
            lvl_reg  <= '0;
            thr_reg  <= '0;
            best_reg <= '0;
            rd_reg   <= '0;
            irq_reg  <= 1'b0;
        end
        else if (cmd.execute)
        begin
            unique case (req_type_t'(type_reg))
                REQ_READ:
                begin
                    priority if (hit_prio)
                        rd_reg <= 32'(prio_reg[LB'(idx)]);
                    else if (hit_pend)
                        rd_reg <= pend_reg[widx*32 +: 32];
                    else if (hit_en)
                        rd_reg <= en_reg[widx*32 +: 32];
                    else if (hit_thr)
                        rd_reg <= 32'(thr_reg);
                    else if (hit_claim)
                    begin
                        rd_reg <= 32'(best);
                        if (best != '0)
                        begin
                            pend_reg[best] <= 1'b0;
                            isv_reg[best]  <= 1'b1;
                        end
                    end
                    else
                        rd_reg <= '0;
                end
                REQ_WRITE:
                begin
                    rd_reg <= '0;
                    priority if (hit_prio)
                    begin
                        if (idx != 0)
                            prio_reg[LB'(idx)] <= data_reg[PRIORITY_BITS-1:0];
                    end
                    else if (hit_en)
                        en_reg[widx*32 +: 32] <= data_reg & valid_mask[widx*32 +: 32];
                    else if (hit_thr)
                        thr_reg <= data_reg[PRIORITY_BITS-1:0];
                    else if (hit_claim && cl_ok)
                    begin
                        isv_reg[cl_line] <= 1'b0;
                        if (lvl_reg[cl_line] && !pend_reg[cl_line])
                            pend_reg[cl_line] <= 1'b1;
                    end
                    else
                    begin
                        // Unmapped, misaligned, pending and rejected complete writes do nothing.
                    end
                end
                REQ_LEVEL:
                begin
                    rd_reg <= '0;
                    if (line_reg != 0 && 32'(line_reg) < 32'(NUM_LINES))
                    begin
                        lvl_reg[sl] <= level_reg;
                        if (level_reg && !pend_reg[sl] && !isv_reg[sl])
                            pend_reg[sl] <= 1'b1;
                    end
                end
                default: rd_reg <= '0;
            endcase
        end
        else if (cmd.evaluate)
        begin
            best_reg <= best;
            irq_reg  <= (best != '0);
        end
    end

    assign read_data   = rd_reg;
    assign irq_to_hart = irq_reg;

    // Line 0 never becomes pending, enabled or in service.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0] && !en_reg[0] && !isv_reg[0])
        else $error("reserved line state set");
    // A line is never pending and in service at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & isv_reg) == '0)
        else $error("line pending while in service");
    // The interrupt request agrees with the selected line.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.evaluate) |-> irq_reg == (best_reg != '0))
        else $error("irq mismatch");
endmodule
